// File: design/swct_pkg.sv
// Shared types, constants and helpers for the stream window credit table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package swct_pkg;

    localparam int REQ_W    = 2;
    localparam int SID_W    = 31;
    localparam int WIN_W    = 31;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    localparam logic [WIN_W-1:0] WIN_MAX            = {WIN_W{1'b1}};
    localparam logic [WIN_W-1:0] DEFAULT_WINDOW_RST = WIN_W'(65535);

    typedef enum logic [REQ_W-1:0] {
        REQ_OPEN   = 2'd0,
        REQ_CLOSE  = 2'd1,
        REQ_UPDATE = 2'd2,
        REQ_SEND   = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [SID_W-1:0] stream;
        logic [WIN_W-1:0] window;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic [WIN_W-1:0] granted;
        logic             update_notify;
        logic [SID_W-1:0] update_stream;
        logic [WIN_W-1:0] update_amount;
    } result_t;

    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                 input logic [WIN_W-1:0] b);
        logic [WIN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[WIN_W] ? WIN_MAX : sum[WIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/swct_mem.sv
// Entry memory: stream id and window per table slot, one write and one read port.
// Read data is registered. Depends on swct_pkg.
`default_nettype none

module swct_mem
    import swct_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire entry_t            wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output entry_t                 rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/swct_ctrl.sv
// Request sequencer: scans the entry memory, applies open, close, update and send,
// and keeps valid bits, default window and connection window. Depends on swct_pkg.
`default_nettype none

module swct_ctrl
    import swct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int IDX_W         = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire req_t             req_type,
    input  wire logic [SID_W-1:0] req_stream,
    input  wire logic [WIN_W-1:0] req_amount,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [WIN_W-1:0] cfg_data,
    output logic                  mem_wr_en,
    output logic [IDX_W-1:0]      mem_wr_addr,
    output entry_t                mem_wr_data,
    output logic [IDX_W-1:0]      mem_rd_addr,
    input  wire entry_t           mem_rd_data,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_MISS = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam result_t RES_ZERO = '{
        status: STATUS_OK, granted: '0, update_notify: 1'b0,
        update_stream: '0, update_amount: '0
    };

    state_t                   state_reg, state_next;
    req_t                     req_reg, req_next;
    logic [SID_W-1:0]         sid_reg, sid_next;
    logic [WIN_W-1:0]         amt_reg, amt_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]         slot_reg, slot_next;
    logic [WIN_W-1:0]         win_reg, win_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [WIN_W-1:0]         default_reg, default_next;
    logic [WIN_W-1:0]         conn_reg, conn_next;
    result_t                  res_reg, res_next;

    logic                     accept;
    logic                     last;
    logic                     hit;
    logic [WIN_W-1:0]         grant;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = req_valid && req_ready;
    assign last      = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign hit       = valid_reg[idx_reg] && (mem_rd_data.stream == sid_reg);
    assign grant     = (amt_reg < win_reg) ? amt_reg : win_reg;

    assign mem_rd_addr = (state_reg == ST_SCAN && !last) ? idx_reg + IDX_W'(1) : '0;

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        sid_next        = sid_reg;
        amt_next        = amt_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        slot_next       = slot_reg;
        win_next        = win_reg;
        valid_next      = valid_reg;
        default_next    = default_reg;
        conn_next       = conn_reg;
        res_next        = res_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = slot_reg;
        mem_wr_data     = '{stream: sid_reg, window: default_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next        = req_type;
                    sid_next        = req_stream;
                    amt_next        = req_amount;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    free_idx_next   = '0;
                    if (req_type == REQ_UPDATE && req_stream == '0) begin
                        conn_next  = sat_add(conn_reg, req_amount);
                        res_next   = RES_ZERO;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!valid_reg[idx_reg] && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (hit) begin
                    slot_next  = idx_reg;
                    win_next   = mem_rd_data.window;
                    state_next = ST_EXEC;
                end else if (last) begin
                    state_next = ST_MISS;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_EXEC: begin
                res_next = RES_ZERO;
                unique case (req_reg)
                    REQ_OPEN: begin
                        mem_wr_en = 1'b1;
                    end
                    REQ_CLOSE: begin
                        valid_next[slot_reg] = 1'b0;
                    end
                    REQ_UPDATE: begin
                        mem_wr_en              = 1'b1;
                        mem_wr_data.window     = sat_add(win_reg, amt_reg);
                        res_next.update_notify = 1'b1;
                        res_next.update_stream = sid_reg;
                        res_next.update_amount = amt_reg;
                    end
                    REQ_SEND: begin
                        mem_wr_en          = 1'b1;
                        mem_wr_data.window = win_reg - grant;
                        res_next.granted   = grant;
                    end
                    default: begin
                        res_next = RES_ZERO;
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_MISS: begin
                res_next = RES_ZERO;
                if (req_reg == REQ_OPEN) begin
                    if (free_found_reg) begin
                        mem_wr_en                = 1'b1;
                        mem_wr_addr              = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                    end else begin
                        res_next.status = STATUS_FULL;
                    end
                end else begin
                    res_next.status = STATUS_UNKNOWN;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            default_next = cfg_data;
            conn_next    = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            default_reg <= DEFAULT_WINDOW_RST;
            conn_reg    <= DEFAULT_WINDOW_RST;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            default_reg <= default_next;
            conn_reg    <= conn_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        sid_reg        <= sid_next;
        amt_reg        <= amt_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        slot_reg       <= slot_next;
        win_reg        <= win_next;
        res_reg        <= res_next;
    end

endmodule

`default_nettype wire

// File: design/swct_out.sv
// Output register: holds one finished result and drives the master stream side.
// Depends on swct_pkg.
`default_nettype none

module swct_out
    import swct_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire result_t               in_res,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic [M_TUSER_W-1:0]       m_tuser
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                res_next = in_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W - WIN_W - SID_W - WIN_W)'(0),
                       res_reg.update_amount, res_reg.update_stream, res_reg.granted};
    assign m_tuser  = {res_reg.update_notify, res_reg.status};

endmodule

`default_nettype wire

// File: design/stream_window_credit_table_core.sv
// Per-stream receive-window credit table: open, close, window update and send grant.
// Top level; depends on swct_pkg, swct_mem, swct_ctrl and swct_out.
//
// One request in, one result out. The stream table lives in a single-port-read
// memory that is scanned one entry per cycle, lowest index first, until the stream
// id matches a valid entry. A miss (unknown stream, or opening a new stream) scans
// the whole table; a window update for stream 0 updates the connection window
// directly, with no scan. One finished result is buffered, so the next request is
// taken while a result waits on m_tready. Valid bits sit in flip-flops, so no
// clearing pass runs after reset. The config channel writes the default window and
// reloads the connection window; write it only while idle.
`default_nettype none

module stream_window_credit_table_core
    import swct_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // stream_id[30:0], amount[61:31], zero pad
    input  wire logic [S_TUSER_W-1:0] s_tuser,   // req_type[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // granted[30:0], update_stream[61:31],
                                                 // update_amount[92:62], zero pad
    output logic [M_TUSER_W-1:0]      m_tuser,   // status[1:0], update_notify[2]
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [WIN_W-1:0]     cfg_data   // default_window[30:0]
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    swct_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    swct_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (req_t'(s_tuser[REQ_W-1:0])),
        .req_stream  (s_tdata[SID_W-1:0]),
        .req_amount  (s_tdata[SID_W+WIN_W-1:SID_W]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    swct_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_res   (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: design/swct_checker.sv
// Port-level checks for the stream window credit table and their bind to the top.
// Depends on swct_pkg and stream_window_credit_table_core.
`default_nettype none

module swct_checker
    import swct_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request accepted while one is in flight");

    a_notify_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STATUS_W] |->
            m_tuser[STATUS_W-1:0] == STATUS_OK && m_tdata[WIN_W-1:0] == '0)
        else $error("notify with error status or nonzero grant");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STATUS_W-1:0] != STATUS_OK |->
            !m_tuser[STATUS_W] && m_tdata[WIN_W-1:0] == '0 &&
            (m_tuser[STATUS_W-1:0] == STATUS_UNKNOWN || m_tuser[STATUS_W-1:0] == STATUS_FULL))
        else $error("error result carries grant, notify or bad status code");

endmodule

bind stream_window_credit_table_core swct_checker u_swct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// File: bench/tb_stream_window_credit_table_core.sv
// Self-checking bench for stream_window_credit_table_core: a window ledger class predicts
// every result from the accepted requests and checks it; tasks drive the request stream.
// Depends on swct_pkg and the stream_window_credit_table_core RTL.

module tb_stream_window_credit_table_core;
    import swct_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;
    localparam int SETTLE      = 2 * TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 234;

    class window_ledger;
        bit               slot_used[TABLE_DEPTH];
        logic [SID_W-1:0] slot_stream[TABLE_DEPTH];
        logic [WIN_W-1:0] slot_window[TABLE_DEPTH];
        logic [WIN_W-1:0] default_window;
        logic [WIN_W-1:0] connection_window;
        result_t          pending_results[$];
        int unsigned      error_count;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            default_window    = DEFAULT_WINDOW_RST;
            connection_window = DEFAULT_WINDOW_RST;
            error_count       = 0;
        endfunction

        function logic [WIN_W-1:0] clamp_add(logic [WIN_W-1:0] a, logic [WIN_W-1:0] b);
            logic [WIN_W:0] total;
            total = {1'b0, a} + {1'b0, b};
            return (total > {1'b0, WIN_MAX}) ? WIN_MAX : total[WIN_W-1:0];
        endfunction

        function void load_default(logic [WIN_W-1:0] value);
            default_window    = value;
            connection_window = value;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function void note_request(req_t req, logic [SID_W-1:0] sid, logic [WIN_W-1:0] amt);
            result_t res;
            int      hit;
            int      vacant;
            hit    = -1;
            vacant = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (hit < 0 && slot_used[i] && slot_stream[i] == sid) hit = i;
                if (vacant < 0 && !slot_used[i]) vacant = i;
            end
            res = '0;
            res.status = STATUS_OK;
            case (req)
                REQ_OPEN: begin
                    if (hit >= 0) begin
                        slot_window[hit] = default_window;
                    end else if (vacant < 0) begin
                        res.status = STATUS_FULL;
                    end else begin
                        slot_used[vacant]   = 1'b1;
                        slot_stream[vacant] = sid;
                        slot_window[vacant] = default_window;
                    end
                end
                REQ_CLOSE: begin
                    if (hit < 0) res.status = STATUS_UNKNOWN;
                    else slot_used[hit] = 1'b0;
                end
                REQ_UPDATE: begin
                    if (sid == '0) begin
                        connection_window = clamp_add(connection_window, amt);
                    end else if (hit < 0) begin
                        res.status = STATUS_UNKNOWN;
                    end else begin
                        slot_window[hit]  = clamp_add(slot_window[hit], amt);
                        res.update_notify = 1'b1;
                        res.update_stream = sid;
                        res.update_amount = amt;
                    end
                end
                default: begin
                    if (hit < 0) begin
                        res.status = STATUS_UNKNOWN;
                    end else begin
                        res.granted      = (amt < slot_window[hit]) ? amt : slot_window[hit];
                        slot_window[hit] = slot_window[hit] - res.granted;
                    end
                end
            endcase
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                error_count++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
            result_t want;
            if (pending_results.size() == 0) begin
                $error("result transaction with no request pending: tdata %h tuser %h",
                       data, user);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(user[1:0]));
            compare_field("update_notify", 32'(want.update_notify), 32'(user[2]));
            compare_field("granted", 32'(want.granted), 32'(data[30:0]));
            compare_field("update_stream", 32'(want.update_stream), 32'(data[61:31]));
            compare_field("update_amount", 32'(want.update_amount), 32'(data[92:62]));
        endfunction
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [WIN_W-1:0]     cfg_data  = '0;

    window_ledger     ledger;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      cycle_count   = 0;
    logic [SID_W-1:0] stream_pool[POOL_SIZE];

    stream_window_credit_table_core #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stream_window_credit_table_core verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) ledger.check_result(m_tdata, m_tuser);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic drive_request(req_t req, logic [SID_W-1:0] sid, logic [WIN_W-1:0] amt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amt, sid};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
        ledger.note_request(req, sid, amt);
    endtask

    // hold the request side until every result is back, then write the register
    task automatic write_default(logic [WIN_W-1:0] value);
        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        ledger.load_default(value);
    endtask

    function automatic logic [SID_W-1:0] pick_stream();
        if ($urandom_range(9) == 0) return SID_W'($urandom());
        return stream_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [WIN_W-1:0] pick_amount();
        case ($urandom_range(9))
            0:       return '0;
            1:       return WIN_MAX;
            2, 3:    return WIN_W'($urandom_range(64));
            4, 5:    return WIN_W'($urandom_range(70000));
            default: return WIN_W'($urandom());
        endcase
    endfunction

    task automatic run_random(int count);
        int   roll;
        req_t req;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 30) req = REQ_OPEN;
            else if (roll < 45) req = REQ_CLOSE;
            else if (roll < 70) req = REQ_UPDATE;
            else req = REQ_SEND;
            drive_request(req, pick_stream(), pick_amount());
        end
    endtask

    initial begin
        ledger = new();
        for (int i = 0; i < POOL_SIZE; i++) begin
            stream_pool[i] = (i < 12) ? SID_W'(i) : SID_W'($urandom());
        end
        stream_pool[POOL_SIZE - 1] = WIN_MAX;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window after reset comes from the reset default
        drive_request(REQ_OPEN, 31'd9, 31'd0);
        drive_request(REQ_SEND, 31'd9, WIN_MAX);

        write_default(WIN_MAX);
        drive_request(REQ_OPEN, 31'd0, 31'd0);
        drive_request(REQ_OPEN, WIN_MAX, WIN_MAX);
        drive_request(REQ_UPDATE, WIN_MAX, 31'd1);
        drive_request(REQ_UPDATE, 31'd0, WIN_MAX);
        drive_request(REQ_SEND, 31'd0, WIN_MAX);
        drive_request(REQ_SEND, 31'd0, 31'd5);
        drive_request(REQ_OPEN, 31'd0, 31'd0);
        drive_request(REQ_CLOSE, 31'd5, 31'd0);
        drive_request(REQ_UPDATE, 31'd5, 31'd7);
        drive_request(REQ_SEND, 31'd5, 31'd7);
        drive_request(REQ_CLOSE, 31'd9, 31'd0);
        // fill the table, then one open too many
        for (int i = 1; i <= TABLE_DEPTH - 2; i++) drive_request(REQ_OPEN, SID_W'(i), 31'd0);
        drive_request(REQ_OPEN, 31'd100, 31'd0);

        write_default(WIN_W'($urandom_range(1, 100000)));
        send_idle_pct = 9;
        recv_idle_pct = 75;
        run_random(PHASE_ITEMS);

        write_default('0);
        send_idle_pct = 75;
        recv_idle_pct = 9;
        run_random(PHASE_ITEMS);

        write_default(DEFAULT_WINDOW_RST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS / 2);
        write_default(WIN_W'($urandom()));
        run_random(PHASE_ITEMS / 2);

        s_tvalid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (ledger.error_count == 0 && ledger.outstanding() == 0) begin
            $display("stream_window_credit_table_core verification clean");
        end else begin
            $display("stream_window_credit_table_core verification failed");
        end
        $finish;
    end

endmodule
